// ----- rtl/core/fragment_reassembly_tracker_defines.svh -----
// Assertion macros shared by the fragment reassembly tracker modules.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef FRAGMENT_REASSEMBLY_TRACKER_DEFINES_SVH
`define FRAGMENT_REASSEMBLY_TRACKER_DEFINES_SVH
`ifndef SYNTHESIS
`define FRT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define FRT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define FRT_ASSERT(lbl, prop, msg)
`define FRT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/core/frt_pkg.sv -----
package frt_pkg;

	// Table geometry.
	localparam int NUM_SLOTS    = 8;
	localparam int MAX_CHUNKS   = 8;
	localparam int HEADER_BYTES = 2;

	localparam int SLOT_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CHUNK_W = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
	localparam int MASK_W  = MAX_CHUNKS;

	// Field widths.
	localparam int MAC_W    = 48;
	localparam int MSG_W    = 8;
	localparam int IDX_W    = 4;
	localparam int FLEN_W   = 8;
	localparam int STAT_W   = 3;
	localparam int OSLOT_W  = 3;
	localparam int OCHUNK_W = 3;
	localparam int PLEN_W   = 8;
	localparam int BYTES_W  = 11;

	localparam logic [FLEN_W-1:0] HEADER_LEN = FLEN_W'(HEADER_BYTES);
	localparam logic [IDX_W-1:0]  MAX_TOTAL  = IDX_W'(MAX_CHUNKS);

	localparam int S_TDATA_W = 72;
	localparam int OUT_BITS  = STAT_W + OSLOT_W + OCHUNK_W + PLEN_W + BYTES_W;
	localparam int M_TDATA_W = 32;
	localparam int OUT_PAD   = M_TDATA_W - OUT_BITS;

	typedef enum logic [STAT_W-1:0] {
		STAT_REJECTED = 3'd0,
		STAT_SINGLE   = 3'd1,
		STAT_STORED   = 3'd2,
		STAT_DUP      = 3'd3,
		STAT_FULL     = 3'd4,
		STAT_COMPLETE = 3'd5
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic lookup;
		logic commit;
	} cmd_t;

endpackage

// ----- rtl/core/fragment_reassembly_tracker.sv -----
// Channel   Direction  Fields (lowest bit first)
// s_*       in         src_mac, msg_id, chunk_index, chunk_total, frame_length
// m_*       out        status, slot, store_chunk, payload_length, packet_length
//
// Each fragment is handled in order: the word is captured, then all slots are
// compared in parallel against the sender and message id, then the slot table
// is updated and the result register is loaded.
// The next word is taken in the cycle after the result register is loaded, even
// while that result still waits; no new word is taken before the last one is through.
// A stalled sink holds the update step until the waiting result is taken.
// Reset clears the slot valid bits at once; no clearing pass is needed.

module fragment_reassembly_tracker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// s_tdata: src_mac[47:0], msg_id[55:48], chunk_index[59:56],
	// chunk_total[63:60], frame_length[71:64]
	input  logic [frt_pkg::S_TDATA_W-1:0] s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// m_tdata: status[2:0], slot[5:3], store_chunk[8:6], payload_length[16:9],
	// packet_length[27:17], zeros[31:28]
	output logic [frt_pkg::M_TDATA_W-1:0] m_tdata
);

	frt_pkg::cmd_t cmd;

	// The controller owns both handshakes and sequences the datapath.
	frt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	// The datapath holds the captured word, the slot table and the result register.
	frt_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.cmd     (cmd),
		.m_tdata (m_tdata)
	);

endmodule

// ----- rtl/core/frt_dp.sv -----
`include "fragment_reassembly_tracker_defines.svh"

module frt_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [frt_pkg::S_TDATA_W-1:0]   s_tdata,
	input  frt_pkg::cmd_t                   cmd,
	output logic [frt_pkg::M_TDATA_W-1:0]   m_tdata
);

	// Captured fragment descriptor.
	logic [frt_pkg::MAC_W-1:0]  mac_q;
	logic [frt_pkg::MSG_W-1:0]  msg_q;
	logic [frt_pkg::IDX_W-1:0]  idx_q;
	logic [frt_pkg::IDX_W-1:0]  total_q;
	logic [frt_pkg::FLEN_W-1:0] flen_q;

	// Slot table.
	logic [frt_pkg::NUM_SLOTS-1:0] slot_valid_q;
	logic [frt_pkg::MAC_W-1:0]     slot_mac_q   [frt_pkg::NUM_SLOTS];
	logic [frt_pkg::MSG_W-1:0]     slot_msg_q   [frt_pkg::NUM_SLOTS];
	logic [frt_pkg::MASK_W-1:0]    slot_mask_q  [frt_pkg::NUM_SLOTS];
	logic [frt_pkg::BYTES_W-1:0]   slot_bytes_q [frt_pkg::NUM_SLOTS];

	// Lookup results.
	logic                        reject_c, single_c, hit_c, free_c;
	logic [frt_pkg::SLOT_W-1:0]  hit_slot_c, free_slot_c;
	logic                        reject_q, single_q, hit_q, free_any_q;
	logic [frt_pkg::SLOT_W-1:0]  hit_slot_q, free_slot_q;
	logic [frt_pkg::PLEN_W-1:0]  plen_q;

	// Update stage.
	logic [frt_pkg::SLOT_W-1:0]   sel_slot;
	logic [frt_pkg::MASK_W-1:0]   old_mask, new_mask, full_mask;
	logic [frt_pkg::BYTES_W-1:0]  old_bytes, new_bytes;
	logic [frt_pkg::CHUNK_W-1:0]  chunk;
	logic                         fresh, complete, alloc_ok, table_wr;
	frt_pkg::status_t             res_status;
	logic [frt_pkg::OSLOT_W-1:0]  res_slot;
	logic [frt_pkg::OCHUNK_W-1:0] res_chunk;
	logic [frt_pkg::PLEN_W-1:0]   res_plen;
	logic [frt_pkg::BYTES_W-1:0]  res_pkt;
	logic [frt_pkg::M_TDATA_W-1:0] out_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mac_q   <= s_tdata[47:0];
			msg_q   <= s_tdata[55:48];
			idx_q   <= s_tdata[59:56];
			total_q <= s_tdata[63:60];
			flen_q  <= s_tdata[71:64];
		end
	end

	// Parallel compare against every slot; the lowest index wins.
	always_comb begin
		hit_c       = 1'b0;
		free_c      = 1'b0;
		hit_slot_c  = '0;
		free_slot_c = '0;
		for (int s = frt_pkg::NUM_SLOTS - 1; s >= 0; s--) begin
			if (slot_valid_q[s]) begin
				if (slot_mac_q[s] == mac_q && slot_msg_q[s] == msg_q) begin
					hit_c      = 1'b1;
					hit_slot_c = frt_pkg::SLOT_W'(s);
				end
			end else begin
				free_c      = 1'b1;
				free_slot_c = frt_pkg::SLOT_W'(s);
			end
		end
	end

	assign reject_c = (flen_q < frt_pkg::HEADER_LEN) || (total_q == '0) ||
		(idx_q >= total_q) || (total_q > frt_pkg::MAX_TOTAL);
	assign single_c = (total_q == frt_pkg::IDX_W'(1));

	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			reject_q    <= reject_c;
			single_q    <= single_c;
			hit_q       <= hit_c;
			hit_slot_q  <= hit_slot_c;
			free_any_q  <= free_c;
			free_slot_q <= free_slot_c;
			plen_q      <= flen_q - frt_pkg::HEADER_LEN;
		end
	end

	// A fresh slot starts from an empty mask and a zero byte count.
	always_comb begin
		sel_slot  = hit_q ? hit_slot_q : free_slot_q;
		old_mask  = hit_q ? slot_mask_q[sel_slot] : '0;
		old_bytes = hit_q ? slot_bytes_q[sel_slot] : '0;
		chunk     = idx_q[frt_pkg::CHUNK_W-1:0];
		fresh     = !old_mask[chunk];
		new_mask  = old_mask | (frt_pkg::MASK_W'(1) << chunk);
		new_bytes = fresh ? (old_bytes + frt_pkg::BYTES_W'(plen_q)) : old_bytes;
		for (int i = 0; i < frt_pkg::MASK_W; i++) begin
			full_mask[i] = (frt_pkg::IDX_W'(i) < total_q);
		end
		complete = (new_mask == full_mask);
		alloc_ok = hit_q || free_any_q;
	end

	// A rejected fragment reports all fields as zero, its payload length included.
	always_comb begin
		res_status = frt_pkg::STAT_REJECTED;
		res_slot   = '0;
		res_chunk  = '0;
		res_plen   = plen_q;
		res_pkt    = '0;
		if (reject_q) begin
			res_status = frt_pkg::STAT_REJECTED;
			res_plen   = '0;
		end else if (single_q) begin
			res_status = frt_pkg::STAT_SINGLE;
			res_pkt    = frt_pkg::BYTES_W'(plen_q);
		end else if (!alloc_ok) begin
			res_status = frt_pkg::STAT_FULL;
		end else begin
			res_slot  = frt_pkg::OSLOT_W'(sel_slot);
			res_chunk = fresh ? frt_pkg::OCHUNK_W'(chunk) : '0;
			if (complete) begin
				res_status = frt_pkg::STAT_COMPLETE;
				res_pkt    = new_bytes;
			end else if (fresh) begin
				res_status = frt_pkg::STAT_STORED;
			end else begin
				res_status = frt_pkg::STAT_DUP;
			end
		end
	end

	assign table_wr = cmd.commit && !reject_q && !single_q && alloc_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
		end else if (table_wr) begin
			slot_valid_q[sel_slot] <= !complete;
		end
	end

	always_ff @(posedge clk) begin
		if (table_wr) begin
			slot_mac_q[sel_slot]   <= mac_q;
			slot_msg_q[sel_slot]   <= msg_q;
			slot_mask_q[sel_slot]  <= new_mask;
			slot_bytes_q[sel_slot] <= new_bytes;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_q <= {{frt_pkg::OUT_PAD{1'b0}}, res_pkt, res_plen, res_chunk, res_slot,
				res_status};
		end
	end

	assign m_tdata = out_q;

	`FRT_ASSERT_NEXT(a_hit_is_valid, cmd.lookup, !hit_q || slot_valid_q[hit_slot_q], "matched slot is not valid")
	`FRT_ASSERT_NEXT(a_free_is_free, cmd.lookup, !free_any_q || !slot_valid_q[free_slot_q], "free slot is in use")
	`FRT_ASSERT(a_chunk_in_range, (cmd.commit && !reject_q) |-> (idx_q < total_q), "accepted chunk index is outside its total")

endmodule

// ----- rtl/core/frt_ctrl.sv -----
`include "fragment_reassembly_tracker_defines.svh"

module frt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  logic          m_tready,
	output frt_pkg::cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOKUP,
		S_UPDATE
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign s_tready   = (state_q == S_IDLE);
	assign m_tvalid   = out_valid_q;
	assign cmd.load   = s_tvalid && s_tready;
	assign cmd.lookup = (state_q == S_LOOKUP);
	// The result register may be refilled once its word is taken or it is empty.
	assign cmd.commit = (state_q == S_UPDATE) && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.load) begin
						state_q <= S_LOOKUP;
					end
				end
				S_LOOKUP: begin
					state_q <= S_UPDATE;
				end
				S_UPDATE: begin
					if (cmd.commit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`FRT_ASSERT_NEXT(a_accept_to_lookup, s_tvalid && s_tready, state_q == S_LOOKUP, "accepted word did not start a lookup")
	`FRT_ASSERT(a_commit_room, cmd.commit |-> (!out_valid_q || m_tready), "result overwritten before it was taken")
	`FRT_ASSERT(a_valid_from_commit, $rose(out_valid_q) |-> $past(cmd.commit), "result shown without a commit")

endmodule

// ----- verif/frt_checker.sv -----
module frt_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	// s_tdata: src_mac, msg_id, chunk_index, chunk_total, frame_length
	input  logic [frt_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	// m_tdata: status, slot, store_chunk, payload_length, packet_length, zeros
	input  logic [frt_pkg::M_TDATA_W-1:0] m_tdata,
	output int                            errors,
	output int                            outstanding,
	output int                            results_seen,
	output int                            completions,
	output int                            duplicates,
	output int                            table_drops,
	output int                            rejects
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		frt_pkg::status_t                status;
		logic [frt_pkg::OSLOT_W-1:0]     slot;
		logic [frt_pkg::OCHUNK_W-1:0]    store_chunk;
		logic [frt_pkg::PLEN_W-1:0]      payload_length;
		logic [frt_pkg::BYTES_W-1:0]     packet_length;
	} frag_result_t;

	bit                          slot_busy [frt_pkg::NUM_SLOTS];
	logic [frt_pkg::MAC_W-1:0]   slot_src  [frt_pkg::NUM_SLOTS];
	logic [frt_pkg::MSG_W-1:0]   slot_id   [frt_pkg::NUM_SLOTS];
	logic [frt_pkg::MASK_W-1:0]  slot_seen [frt_pkg::NUM_SLOTS];
	logic [frt_pkg::BYTES_W-1:0] slot_sum  [frt_pkg::NUM_SLOTS];

	frag_result_t fragment_verdicts [$];

	// Applies one fragment to the local copy of the slot table and returns its outcome.
	function automatic frag_result_t track_fragment(input logic [frt_pkg::S_TDATA_W-1:0] w);
		logic [frt_pkg::MAC_W-1:0]  mac;
		logic [frt_pkg::MSG_W-1:0]  id;
		logic [frt_pkg::IDX_W-1:0]  idx;
		logic [frt_pkg::IDX_W-1:0]  total;
		logic [frt_pkg::FLEN_W-1:0] flen;
		logic [frt_pkg::PLEN_W-1:0] plen;
		logic [frt_pkg::MASK_W:0]   span;
		frag_result_t               r;
		int                         hit;
		int                         vacant;
		bit                         fresh;
		mac   = w[47:0];
		id    = w[55:48];
		idx   = w[59:56];
		total = w[63:60];
		flen  = w[71:64];
		r = '0;
		r.status = frt_pkg::STAT_REJECTED;
		if (flen < frt_pkg::HEADER_LEN || total == 0 || idx >= total ||
				total > frt_pkg::MAX_TOTAL)
			return r;
		plen = flen - frt_pkg::HEADER_LEN;
		r.payload_length = plen;
		if (total == 1) begin
			r.status = frt_pkg::STAT_SINGLE;
			r.packet_length = frt_pkg::BYTES_W'(plen);
			return r;
		end
		hit = -1;
		vacant = -1;
		for (int s = 0; s < frt_pkg::NUM_SLOTS; s++) begin
			if (slot_busy[s]) begin
				if (hit < 0 && slot_src[s] == mac && slot_id[s] == id)
					hit = s;
			end else if (vacant < 0) begin
				vacant = s;
			end
		end
		if (hit < 0) begin
			if (vacant < 0) begin
				r.status = frt_pkg::STAT_FULL;
				return r;
			end
			hit = vacant;
			slot_busy[hit] = 1'b1;
			slot_src[hit]  = mac;
			slot_id[hit]   = id;
			slot_seen[hit] = '0;
			slot_sum[hit]  = '0;
		end
		fresh = !slot_seen[hit][idx];
		if (fresh) begin
			slot_seen[hit][idx] = 1'b1;
			slot_sum[hit] = slot_sum[hit] + frt_pkg::BYTES_W'(plen);
		end
		r.slot = frt_pkg::OSLOT_W'(hit);
		r.store_chunk = fresh ? frt_pkg::OCHUNK_W'(idx) : '0;
		span = ({{frt_pkg::MASK_W{1'b0}}, 1'b1} << total) - 1'b1;
		if (slot_seen[hit] == span[frt_pkg::MASK_W-1:0]) begin
			r.status = frt_pkg::STAT_COMPLETE;
			r.packet_length = slot_sum[hit];
			slot_busy[hit] = 1'b0;
		end else begin
			r.status = fresh ? frt_pkg::STAT_STORED : frt_pkg::STAT_DUP;
		end
		return r;
	endfunction

	task automatic match_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		frag_result_t want;
		frag_result_t verdict;
		if (!arst_n) begin
			for (int s = 0; s < frt_pkg::NUM_SLOTS; s++)
				slot_busy[s] = 1'b0;
			fragment_verdicts.delete();
		end else begin
			// Results are retired before the new fragment is queued, so a word that
			// shows up with nothing waiting is never matched against this cycle's input.
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (fragment_verdicts.size() == 0) begin
					$error("result word 0x%08h arrived with no fragment waiting", m_tdata);
					errors++;
				end else begin
					want = fragment_verdicts.pop_front();
					match_field("status", int'(want.status), int'(m_tdata[2:0]));
					match_field("slot", int'(want.slot), int'(m_tdata[5:3]));
					match_field("store_chunk", int'(want.store_chunk), int'(m_tdata[8:6]));
					match_field("payload_length", int'(want.payload_length),
						int'(m_tdata[16:9]));
					match_field("packet_length", int'(want.packet_length),
						int'(m_tdata[27:17]));
					match_field("padding", 0,
						int'(m_tdata[frt_pkg::M_TDATA_W-1:frt_pkg::OUT_BITS]));
					case (want.status)
						frt_pkg::STAT_COMPLETE: completions++;
						frt_pkg::STAT_DUP:      duplicates++;
						frt_pkg::STAT_FULL:     table_drops++;
						frt_pkg::STAT_REJECTED: rejects++;
						default:                ;
					endcase
				end
			end
			if (s_tvalid && s_tready) begin
				verdict = track_fragment(s_tdata);
				fragment_verdicts = {fragment_verdicts, verdict};
			end
		end
		outstanding = fragment_verdicts.size();
	end

endmodule

// ----- verif/tb_fragment_reassembly_tracker.sv -----
module tb_fragment_reassembly_tracker;

	timeunit 1ns;
	timeprecision 1ps;

	logic                          clk      = 1'b0;
	logic                          arst_n   = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	// s_tdata: src_mac, msg_id, chunk_index, chunk_total, frame_length
	logic [frt_pkg::S_TDATA_W-1:0] s_tdata  = '0;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	// m_tdata: status, slot, store_chunk, payload_length, packet_length, zeros
	logic [frt_pkg::M_TDATA_W-1:0] m_tdata;

	int errors, outstanding, results_seen, completions, duplicates, table_drops, rejects;
	int words_sent = 0;
	// While set, neither side inserts idle cycles.
	bit calm = 1'b0;

	always #2 clk = ~clk;

	fragment_reassembly_tracker dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	frt_checker watch (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.errors       (errors),
		.outstanding  (outstanding),
		.results_seen (results_seen),
		.completions  (completions),
		.duplicates   (duplicates),
		.table_drops  (table_drops),
		.rejects      (rejects)
	);

	// The sink stalls in roughly 17 percent of cycles, except in the calm stretch.
	always @(negedge clk)
		m_tready <= calm || ($urandom_range(0, 99) >= 17);

	function automatic logic [frt_pkg::S_TDATA_W-1:0] pack_frag(
			input logic [frt_pkg::MAC_W-1:0] mac,
			input logic [frt_pkg::MSG_W-1:0] id, input logic [frt_pkg::IDX_W-1:0] idx,
			input logic [frt_pkg::IDX_W-1:0] total, input logic [frt_pkg::FLEN_W-1:0] flen);
		return {flen, total, idx, id, mac};
	endfunction

	// Random frame length that always carries a full header.
	function automatic logic [frt_pkg::FLEN_W-1:0] good_len();
		return frt_pkg::FLEN_W'($urandom_range(frt_pkg::HEADER_BYTES, 255));
	endfunction

	// Drives one fragment word from the falling edge and holds it until the block takes it.
	// A random idle gap may precede the word; back-to-back words keep tvalid high throughout.
	task automatic send_word(input logic [frt_pkg::S_TDATA_W-1:0] w);
		@(negedge clk);
		calm = (words_sent >= 300 && words_sent < 450);
		if (!calm && $urandom_range(0, 99) < 17) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= w;
		do @(posedge clk); while (!s_tready);
		words_sent++;
	endtask

	initial begin
		logic [frt_pkg::MAC_W-1:0]     rmac [10];
		logic [frt_pkg::MSG_W-1:0]     rid  [10];
		logic [frt_pkg::IDX_W-1:0]     rtot [10];
		logic [frt_pkg::S_TDATA_W-1:0] frags [$];
		logic [frt_pkg::S_TDATA_W-1:0] w;
		logic [frt_pkg::IDX_W-1:0]     idx;
		logic [frt_pkg::IDX_W-1:0]     total;
		int                            k, p, q, passes;
		bit                            dirty;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part. Malformed descriptors: frame shorter than the header (both short
		// lengths), a total of zero, a total above the table limit, an index equal to the total.
		send_word(pack_frag(48'h0123_4567_89AB, 8'h10, 4'd0, 4'd2, 8'd0));
		send_word(pack_frag(48'h0123_4567_89AB, 8'h10, 4'd0, 4'd2, 8'd1));
		send_word(pack_frag(48'h0123_4567_89AB, 8'h10, 4'd0, 4'd0, 8'd40));
		send_word(pack_frag(48'h0123_4567_89AB, 8'h10, 4'd15, 4'd15, 8'd40));
		send_word(pack_frag(48'h0123_4567_89AB, 8'h10, 4'd3, 4'd3, 8'd40));
		// Single-chunk messages at both payload extremes.
		send_word(pack_frag(48'hFFFF_FFFF_FFFF, 8'hFF, 4'd0, 4'd1, 8'd255));
		send_word(pack_frag(48'h0000_0000_0000, 8'h00, 4'd0, 4'd1, 8'd2));
		// A duplicate that still completes: the repeated chunk carries a smaller total
		// whose full mask already matches the slot, so it reports completion without storing.
		send_word(pack_frag(48'hFFFF_FFFF_FFFF, 8'h00, 4'd0, 4'd4, 8'd20));
		send_word(pack_frag(48'hFFFF_FFFF_FFFF, 8'h00, 4'd1, 4'd4, 8'd30));
		send_word(pack_frag(48'hFFFF_FFFF_FFFF, 8'h00, 4'd1, 4'd2, 8'd31));
		// Three messages that share either the sender or the message id must stay apart.
		send_word(pack_frag(48'hA5A5_5A5A_0F0F, 8'h01, 4'd0, 4'd2, 8'd10));
		send_word(pack_frag(48'hA5A5_5A5A_0F0F, 8'h02, 4'd0, 4'd2, 8'd11));
		send_word(pack_frag(48'h5A5A_A5A5_F0F0, 8'h01, 4'd0, 4'd2, 8'd12));
		send_word(pack_frag(48'hA5A5_5A5A_0F0F, 8'h01, 4'd1, 4'd2, 8'd13));
		send_word(pack_frag(48'hA5A5_5A5A_0F0F, 8'h02, 4'd1, 4'd2, 8'd14));
		send_word(pack_frag(48'h5A5A_A5A5_F0F0, 8'h01, 4'd1, 4'd2, 8'd15));
		// Largest message, chunks in reverse order with a plain duplicate in the middle;
		// eight full frames give the largest packet length.
		for (int c = 7; c >= 0; c--) begin
			send_word(pack_frag(48'h0, 8'hFF, frt_pkg::IDX_W'(c), 4'd8, 8'd255));
			if (c == 3)
				send_word(pack_frag(48'h0, 8'hFF, frt_pkg::IDX_W'(c), 4'd8, 8'd100));
		end

		// Random part, in rounds. Each round opens a handful of messages and sends all of
		// their chunks shuffled together, so up to eight messages are in flight at once.
		// Some rounds open nine or ten to run the table full. Noise words (malformed or
		// single-chunk), duplicates and fragments with a conflicting total are mixed in.
		while (words_sent < 870) begin
			k = ($urandom_range(0, 99) < 15) ? $urandom_range(9, 10) : $urandom_range(1, 8);
			frags.delete();
			for (int m = 0; m < k; m++) begin
				rmac[m] = {16'($urandom_range(0, 65535)), 32'($urandom)};
				rid[m]  = frt_pkg::MSG_W'($urandom_range(0, 255));
				rtot[m] = frt_pkg::IDX_W'($urandom_range(2, frt_pkg::MAX_CHUNKS));
				for (int c = 0; c < rtot[m]; c++)
					frags = {frags, pack_frag(rmac[m], rid[m], frt_pkg::IDX_W'(c), rtot[m],
						good_len())};
			end
			for (p = frags.size() - 1; p > 0; p--) begin
				q = $urandom_range(0, p);
				w = frags[p];
				frags[p] = frags[q];
				frags[q] = w;
			end

			dirty = 1'b0;
			foreach (frags[i]) begin
				send_word(frags[i]);
				idx = frags[i][59:56];
				if ($urandom_range(0, 99) < 4) begin
					// Same chunk again, with a new frame length.
					w = frags[i];
					w[71:64] = good_len();
					send_word(w);
					dirty = 1'b1;
				end else if ($urandom_range(0, 99) < 2) begin
					// Same chunk claiming another total; the index stays inside the real
					// total so the slot can still be finished by the clean-up pass.
					w = frags[i];
					w[63:60] = frt_pkg::IDX_W'($urandom_range(idx + 1, frt_pkg::MAX_CHUNKS));
					send_word(w);
					dirty = 1'b1;
				end
				if ($urandom_range(0, 99) < 10) begin
					w = pack_frag({16'($urandom_range(0, 65535)), 32'($urandom)},
						frt_pkg::MSG_W'($urandom_range(0, 255)),
						frt_pkg::IDX_W'($urandom_range(0, 15)),
						frt_pkg::IDX_W'($urandom_range(0, 15)),
						frt_pkg::FLEN_W'($urandom_range(0, 255)));
					case ($urandom_range(0, 4))
						0: w[71:64] = frt_pkg::FLEN_W'($urandom_range(0,
							frt_pkg::HEADER_BYTES - 1));
						1: w[63:60] = '0;
						2: w[63:60] = frt_pkg::IDX_W'($urandom_range(frt_pkg::MAX_CHUNKS + 1,
							15));
						3: begin
							total = frt_pkg::IDX_W'($urandom_range(1, frt_pkg::MAX_CHUNKS));
							w[63:60] = total;
							w[59:56] = frt_pkg::IDX_W'($urandom_range(total, 15));
						end
						default: begin
							w[63:60] = 4'd1;
							w[59:56] = 4'd0;
						end
					endcase
					send_word(w);
				end
			end

			// Duplicates, conflicting totals and table-full drops can leave a slot open.
			// Resending every chunk of every message in order closes them all; after an
			// overfull round a second pass catches messages that found no slot the first time.
			if (dirty || k > frt_pkg::NUM_SLOTS) begin
				passes = (k > frt_pkg::NUM_SLOTS) ? 2 : 1;
				repeat (passes)
					for (int m = 0; m < k; m++)
						for (int c = 0; c < rtot[m]; c++)
							send_word(pack_frag(rmac[m], rid[m], frt_pkg::IDX_W'(c),
								rtot[m], good_len()));
			end
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (outstanding == 0);
		// Keep the clock running so a stray extra result would still be caught.
		repeat (12) @(posedge clk);

		$display("Sent %0d fragment words and checked %0d result words.",
			words_sent, results_seen);
		$display("Outcomes: %0d completed, %0d duplicates, %0d table-full drops, %0d rejected.",
			completions, duplicates, table_drops, rejects);
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Watchdog: fires far beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/frt_pkg.sv
rtl/core/frt_dp.sv
rtl/core/frt_ctrl.sv
rtl/core/fragment_reassembly_tracker.sv
verif/frt_checker.sv
verif/tb_fragment_reassembly_tracker.sv
